// File: rtl/svgr_pkg.sv
// Shared constants and types of the stereo volume gain ramp.
package svgr_pkg;

    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int GAIN_FRAC_BITS_DEF = 23;
    localparam int TABLE_DEPTH_DEF    = 128;
    localparam int COUNT_BITS_DEF     = 17;

    localparam int GAIN_BITS  = 24;
    localparam int EXTRA_BITS = 24;
    localparam int CUR_BITS   = GAIN_BITS + EXTRA_BITS;
    localparam int RATE_BITS  = 18;
    localparam int PCT_BITS   = 7;
    localparam int MS_BITS    = 9;

    localparam logic [RATE_BITS-1:0] RATE_RESET  = 18'd48000;
    localparam logic [PCT_BITS-1:0]  NO_TARGET   = 7'd127;
    localparam logic [PCT_BITS-1:0]  MAX_PERCENT = 7'd100;

    localparam logic [MS_BITS-1:0] MS_FIRST  = 9'd10;
    localparam logic [MS_BITS-1:0] MS_NORMAL = 9'd100;
    localparam logic [MS_BITS-1:0] MS_UNMUTE = 9'd500;

    typedef struct packed {
        logic hold;
        logic ramping;
    } lane_status_t;

    function automatic logic [PCT_BITS-1:0] clamp_percent(input logic [PCT_BITS-1:0] p);
        clamp_percent = (p > MAX_PERCENT) ? MAX_PERCENT : p;
    endfunction

endpackage

// File: rtl/stereo_volume_gain_ramp.sv
// Top level of the stereo volume stage with linear gain ramps.
// A request with mode 1 is a gain table write. An audio frame (mode 0) passes from acceptance
// to the output register, when neither target changes, through table read, target check,
// multiply, round and saturate, output load; a new request is taken once the frame is loaded.
// A target change adds ramp setup in that channel's lane: the ramp length comes from the sample
// rate by reciprocal multiplication (a halving for an unmute), then a 48-step serial division
// gives the gain step; both lanes run side by side. Each channel has its own copy of the table
// so both channels read in the same cycle. One frame is in work at a time; the output
// register lets the next request enter while a result waits.
module stereo_volume_gain_ramp #(
    parameter int SAMPLE_BITS    = svgr_pkg::SAMPLE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = svgr_pkg::GAIN_FRAC_BITS_DEF,
    parameter int TABLE_DEPTH    = svgr_pkg::TABLE_DEPTH_DEF,
    parameter int COUNT_BITS     = svgr_pkg::COUNT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [svgr_pkg::RATE_BITS-1:0]      cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                mode,
    input  logic signed [SAMPLE_BITS-1:0]       left_sample,
    input  logic signed [SAMPLE_BITS-1:0]       right_sample,
    input  logic [svgr_pkg::PCT_BITS-1:0]       left_volume,
    input  logic [svgr_pkg::PCT_BITS-1:0]       right_volume,
    input  logic [svgr_pkg::PCT_BITS-1:0]       table_index,
    input  logic [svgr_pkg::GAIN_BITS-1:0]      table_gain,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [SAMPLE_BITS-1:0]       left_out,
    output logic signed [SAMPLE_BITS-1:0]       right_out,
    output logic [1:0]                          ramping
);

    localparam int AW = $clog2(TABLE_DEPTH);

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_READ = 2'd1;
    localparam logic [1:0] T_RUN  = 2'd2;

    logic [1:0]                    state_reg, state_next;
    logic [svgr_pkg::RATE_BITS-1:0] rate_reg;
    logic signed [SAMPLE_BITS-1:0] ls_reg, rs_reg;
    logic [svgr_pkg::PCT_BITS-1:0] lv_reg, rv_reg;
    logic                          ov_reg;
    logic signed [SAMPLE_BITS-1:0] lo_reg, ro_reg;
    logic [1:0]                    ramp_reg;

    logic                          accept;
    logic                          tbl_wr;
    logic                          rd_en;
    logic                          lane_start;
    logic                          adv;
    logic [svgr_pkg::GAIN_BITS-1:0] l_data, r_data;
    logic signed [SAMPLE_BITS-1:0] l_res, r_res;
    svgr_pkg::lane_status_t        l_st, r_st;
    logic [svgr_pkg::PCT_BITS-1:0] l_pct, r_pct;

    assign accept     = in_valid && !in_stall;
    assign in_stall   = state_reg != T_IDLE;
    assign tbl_wr     = accept && mode && ({1'b0, table_index} < 8'(TABLE_DEPTH));
    assign rd_en      = accept && !mode;
    assign l_pct      = svgr_pkg::clamp_percent(left_volume);
    assign r_pct      = svgr_pkg::clamp_percent(right_volume);
    assign lane_start = state_reg == T_READ;
    assign adv        = state_reg == T_RUN && l_st.hold && r_st.hold && (!ov_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE:
            begin
                if (rd_en)
                begin
                    state_next = T_READ;
                end
            end
            T_READ:
            begin
                state_next = T_RUN;
            end
            T_RUN:
            begin
                if (adv)
                begin
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    svgr_ram #(
        .WIDTH (svgr_pkg::GAIN_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_ram_left (
        .clk     (clk),
        .wr_en   (tbl_wr),
        .wr_addr (table_index[AW-1:0]),
        .wr_data (table_gain),
        .rd_en   (rd_en),
        .rd_addr (l_pct[AW-1:0]),
        .rd_data (l_data)
    );

    svgr_ram #(
        .WIDTH (svgr_pkg::GAIN_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_ram_right (
        .clk     (clk),
        .wr_en   (tbl_wr),
        .wr_addr (table_index[AW-1:0]),
        .wr_data (table_gain),
        .rd_en   (rd_en),
        .rd_addr (r_pct[AW-1:0]),
        .rd_data (r_data)
    );

    svgr_lane #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .COUNT_BITS     (COUNT_BITS)
    ) u_lane_left (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (lane_start),
        .percent    (lv_reg),
        .table_data (l_data),
        .rate       (rate_reg),
        .sample     (ls_reg),
        .adv        (adv),
        .result     (l_res),
        .status     (l_st)
    );

    svgr_lane #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .COUNT_BITS     (COUNT_BITS)
    ) u_lane_right (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (lane_start),
        .percent    (rv_reg),
        .table_data (r_data),
        .rate       (rate_reg),
        .sample     (rs_reg),
        .adv        (adv),
        .result     (r_res),
        .status     (r_st)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            rate_reg  <= svgr_pkg::RATE_RESET;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                rate_reg <= cfg_wr_data;
            end
            if (adv)
            begin
                ov_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            ls_reg <= left_sample;
            rs_reg <= right_sample;
            lv_reg <= left_volume;
            rv_reg <= right_volume;
        end
        if (adv)
        begin
            lo_reg   <= l_res;
            ro_reg   <= r_res;
            ramp_reg <= {r_st.ramping, l_st.ramping};
        end
    end

    assign out_valid = ov_reg;
    assign left_out  = lo_reg;
    assign right_out = ro_reg;
    assign ramping   = ramp_reg;

endmodule

// File: rtl/svgr_ram.sv
// Generic single write, single read RAM with registered read data.
module svgr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/svgr_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module svgr_div #(
    parameter int NUM_BITS = 48,
    parameter int DEN_BITS = 17
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    output logic                done,
    output logic [NUM_BITS-1:0] quo
);

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [DEN_BITS-1:0] rem_reg, rem_next;
    logic [DEN_BITS-1:0] den_reg, den_next;
    logic [NUM_BITS-1:0] work_reg, work_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS:0]   diff;

    always_comb
    begin
        trial     = {rem_reg, work_reg[NUM_BITS-1]};
        diff      = trial - {1'b0, den_reg};
        rem_next  = rem_reg;
        den_next  = den_reg;
        work_next = work_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            den_next  = den;
            work_next = num;
            cnt_next  = CNT_BITS'(NUM_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = diff[DEN_BITS-1:0];
                work_next = {work_reg[NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[DEN_BITS-1:0];
                work_next = {work_reg[NUM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        work_reg <= work_next;
    end

    assign done = done_reg;
    assign quo  = work_reg;

endmodule

// File: rtl/svgr_lane.sv
// One channel lane: target tracking, ramp setup, gain scaling and advance.
module svgr_lane #(
    parameter int SAMPLE_BITS    = svgr_pkg::SAMPLE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = svgr_pkg::GAIN_FRAC_BITS_DEF,
    parameter int COUNT_BITS     = svgr_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [svgr_pkg::PCT_BITS-1:0]   percent,
    input  logic [svgr_pkg::GAIN_BITS-1:0]  table_data,
    input  logic [svgr_pkg::RATE_BITS-1:0]  rate,
    input  logic signed [SAMPLE_BITS-1:0]   sample,
    input  logic                            adv,
    output logic signed [SAMPLE_BITS-1:0]   result,
    output svgr_pkg::lane_status_t          status
);

    localparam int CB  = svgr_pkg::CUR_BITS;
    localparam int GB  = svgr_pkg::GAIN_BITS;
    localparam int EB  = svgr_pkg::EXTRA_BITS;
    localparam int PW  = SAMPLE_BITS + GB + 1;
    localparam int RB  = svgr_pkg::RATE_BITS;
    localparam int RPW = RB + 19;

    localparam logic [2:0] L_IDLE = 3'd0;
    localparam logic [2:0] L_LEN  = 3'd1;
    localparam logic [2:0] L_STEP = 3'd2;
    localparam logic [2:0] L_MUL  = 3'd3;
    localparam logic [2:0] L_RND  = 3'd4;
    localparam logic [2:0] L_HOLD = 3'd5;

    localparam logic [COUNT_BITS-1:0] LEN_CAP = '1;
    localparam logic signed [PW:0]    HALF    = {{PW{1'b0}}, 1'b1} << (GAIN_FRAC_BITS - 1);

    localparam logic [RPW-1:0] RECIP_10        = RPW'(419431);
    localparam int             RECIP_10_SHIFT  = 22;
    localparam logic [RPW-1:0] RECIP_100       = RPW'(335545);
    localparam int             RECIP_100_SHIFT = 25;

    logic [2:0]                    state_reg, state_next;
    logic [CB-1:0]                 cur_reg, cur_next;
    logic [GB-1:0]                 tg_reg, tg_next;
    logic signed [CB:0]            step_reg, step_next;
    logic [COUNT_BITS-1:0]         frames_reg, frames_next;
    logic [svgr_pkg::PCT_BITS-1:0] tp_reg, tp_next;
    logic [COUNT_BITS-1:0]         len_reg, len_next;
    logic                          neg_reg, neg_next;
    logic signed [PW-1:0]          prod_reg, prod_next;
    logic signed [SAMPLE_BITS-1:0] res_reg, res_next;
    logic                          ramp_reg, ramp_next;

    logic [svgr_pkg::PCT_BITS-1:0] pct;
    logic [GB-1:0]                 tgt;
    logic [svgr_pkg::MS_BITS-1:0]  ms;
    logic                          div_start;
    logic [CB-1:0]                 div_num;
    logic [COUNT_BITS-1:0]         div_den;
    logic                          div_done;
    logic [CB-1:0]                 div_quo;
    logic [RPW-1:0]                prod10;
    logic [RPW-1:0]                prod100;
    logic [RB-1:0]                 frames_raw;
    logic [COUNT_BITS-1:0]         len_sel;
    logic [CB-1:0]                 full_reg_gain;
    logic signed [PW-1:0]          op_a;
    logic signed [PW-1:0]          op_b;
    logic signed [PW:0]            rsum;
    logic signed [PW:0]            rshift;
    logic [CB:0]                   cur_sum;

    svgr_div #(
        .NUM_BITS (CB),
        .DEN_BITS (COUNT_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        pct = svgr_pkg::clamp_percent(percent);
        tgt = (pct == '0) ? '0 : table_data;
        if (tp_reg == svgr_pkg::NO_TARGET)
        begin
            ms = svgr_pkg::MS_FIRST;
        end
        else if (pct == '0)
        begin
            ms = svgr_pkg::MS_NORMAL;
        end
        else if (tg_reg == '0)
        begin
            ms = svgr_pkg::MS_UNMUTE;
        end
        else
        begin
            ms = svgr_pkg::MS_NORMAL;
        end

        prod10  = RPW'(rate) * RECIP_10;
        prod100 = RPW'(rate) * RECIP_100;
        case (ms)
            svgr_pkg::MS_FIRST:
            begin
                frames_raw = RB'(prod100 >> RECIP_100_SHIFT);
            end
            svgr_pkg::MS_UNMUTE:
            begin
                frames_raw = rate >> 1;
            end
            default:
            begin
                frames_raw = RB'(prod10 >> RECIP_10_SHIFT);
            end
        endcase

        if (32'(frames_raw) > 32'(LEN_CAP))
        begin
            len_sel = LEN_CAP;
        end
        else if (frames_raw == '0)
        begin
            len_sel = COUNT_BITS'(1);
        end
        else
        begin
            len_sel = COUNT_BITS'(frames_raw);
        end

        full_reg_gain = {tg_reg, {EB{1'b0}}};
        op_a = PW'(sample);
        op_b = $signed({{(SAMPLE_BITS + 1){1'b0}}, cur_reg[CB-1:EB]});
        rsum   = {prod_reg[PW-1], prod_reg} + HALF;
        rshift = rsum >>> GAIN_FRAC_BITS;
        cur_sum = {1'b0, cur_reg} + step_reg;

        state_next  = state_reg;
        cur_next    = cur_reg;
        tg_next     = tg_reg;
        step_next   = step_reg;
        frames_next = frames_reg;
        tp_next     = tp_reg;
        len_next    = len_reg;
        neg_next    = neg_reg;
        prod_next   = prod_reg;
        res_next    = res_reg;
        ramp_next   = ramp_reg;
        div_start   = 1'b0;
        div_den     = len_reg;
        if (full_reg_gain > cur_reg)
        begin
            div_num = full_reg_gain - cur_reg;
        end
        else
        begin
            div_num = cur_reg - full_reg_gain;
        end

        case (state_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    if (tp_reg == pct)
                    begin
                        state_next = L_MUL;
                    end
                    else if (tp_reg != svgr_pkg::NO_TARGET && tgt == tg_reg)
                    begin
                        tp_next    = pct;
                        state_next = L_MUL;
                    end
                    else
                    begin
                        tp_next = pct;
                        tg_next = tgt;
                        if ({tgt, {EB{1'b0}}} == cur_reg)
                        begin
                            frames_next = '0;
                            step_next   = '0;
                            state_next  = L_MUL;
                        end
                        else
                        begin
                            len_next   = len_sel;
                            state_next = L_LEN;
                        end
                    end
                end
            end
            L_LEN:
            begin
                neg_next   = full_reg_gain < cur_reg;
                div_start  = 1'b1;
                state_next = L_STEP;
            end
            L_STEP:
            begin
                if (div_done)
                begin
                    step_next   = neg_reg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
                    frames_next = len_reg;
                    state_next  = L_MUL;
                end
            end
            L_MUL:
            begin
                prod_next  = op_a * op_b;
                ramp_next  = frames_reg != '0;
                state_next = L_RND;
            end
            L_RND:
            begin
                if (rshift[PW:SAMPLE_BITS-1] != '0 && rshift[PW:SAMPLE_BITS-1] != '1)
                begin
                    res_next = rshift[PW] ? {1'b1, {(SAMPLE_BITS - 1){1'b0}}}
                                          : {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
                end
                else
                begin
                    res_next = rshift[SAMPLE_BITS-1:0];
                end
                state_next = L_HOLD;
            end
            L_HOLD:
            begin
                if (adv)
                begin
                    if (frames_reg != '0)
                    begin
                        cur_next    = cur_sum[CB-1:0];
                        frames_next = frames_reg - 1'b1;
                        if (frames_reg == COUNT_BITS'(1))
                        begin
                            cur_next  = full_reg_gain;
                            step_next = '0;
                        end
                    end
                    state_next = L_IDLE;
                end
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= L_IDLE;
            cur_reg    <= '0;
            tg_reg     <= '0;
            step_reg   <= '0;
            frames_reg <= '0;
            tp_reg     <= svgr_pkg::NO_TARGET;
        end
        else
        begin
            state_reg  <= state_next;
            cur_reg    <= cur_next;
            tg_reg     <= tg_next;
            step_reg   <= step_next;
            frames_reg <= frames_next;
            tp_reg     <= tp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg  <= len_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
        ramp_reg <= ramp_next;
    end

    assign result         = res_reg;
    assign status.hold    = state_reg == L_HOLD;
    assign status.ramping = ramp_reg;

endmodule
